// ===== rtl/psa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

    localparam int unsigned LEVELS_DEF = 16;
    localparam int unsigned SLOTS_DEF  = 16;

    // wide enough for any level sum and for LEVELS itself
    localparam int unsigned LVL_W = 7;

    localparam logic [2:0] FN_ADD      = 3'd0;
    localparam logic [2:0] FN_REMOVE   = 3'd1;
    localparam logic [2:0] FN_SET      = 3'd2;
    localparam logic [2:0] FN_TICK     = 3'd3;
    localparam logic [2:0] FN_DISPATCH = 3'd4;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_TERM  = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_HUNGER  = 1'b1;

    localparam logic [7:0]  QUANTUM_RST = 8'd3;
    localparam logic [3:0]  HUNGER_RST  = 4'd6;
    localparam logic [15:0] STAMP_MAX   = 16'hFFFF;
    localparam logic [3:0]  NIBBLE_MAX  = 4'd15;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot;
        logic [3:0]  base_priority;
        logic        is_idle;
        logic [1:0]  new_state;
        logic [15:0] running_pc;
    } t_in;

    typedef struct packed {
        logic [3:0] chosen_slot;
        logic       chosen_valid;
        logic       removed_any;
        logic       error;
    } t_out;

    typedef struct packed {
        logic [3:0]  base_level;
        logic [3:0]  boost;
        logic [1:0]  proc_status;
        logic [3:0]  wait_count;
        logic [15:0] order_stamp;
    } t_entry;

    function automatic logic [LVL_W-1:0] level_of(input t_entry e);
        return LVL_W'(e.base_level) + LVL_W'(e.boost);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psa_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psa_mem #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(SLOTS)-1:0] i_waddr,
    input  psa_pkg::t_entry          i_wdata,
    input  logic [$clog2(SLOTS)-1:0] i_addr_a,
    output psa_pkg::t_entry          o_data_a,
    input  logic [$clog2(SLOTS)-1:0] i_addr_b,
    output psa_pkg::t_entry          o_data_b
);
    import psa_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_data_a;
    t_entry r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_data_a <= r_mem[i_addr_a];
        r_data_b <= r_mem[i_addr_b];
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

`default_nettype wire

// ===== rtl/psa_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psa_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_done,
    output logic [7:0]  o_rem
);
    import psa_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_dvd;
    logic [7:0]  r_rem;
    logic [8:0]  trial;
    logic [8:0]  step;

    assign trial = {r_rem, r_dvd[15]};
    assign step  = (trial >= {1'b0, i_divisor}) ? trial - {1'b0, i_divisor} : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[14:0], 1'b0};
            r_rem <= step[7:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/priority_scheduler_with_aging.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake                Payload
// in       in   i_in_valid / o_in_ready  i_in_data  (t_in)
// out      out  o_out_valid / i_out_ready o_out_data (t_out)
// cfg      in   i_cfg_we                 i_cfg_idx, i_cfg_data
//
// One transaction at a time. Tick: a serial remainder for the quantum check,
// then one table scan and one evaluation step per visited slot and per
// occupied level; dispatch likewise. A stamp renumber adds (used slots + 1)
// scans. All scans go through the single entry memory, one entry read per
// cycle. Synchronous active-low reset; a held result does not block the next
// input.

module priority_scheduler_with_aging #(
    parameter int unsigned LEVELS = psa_pkg::LEVELS_DEF,
    parameter int unsigned SLOTS  = psa_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  psa_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output psa_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);
    import psa_pkg::*;

    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned KW = $clog2(SLOTS + 1);

    typedef enum logic [21:0] {
        S_IDLE    = 22'b0000000000000000000001,
        S_DONE    = 22'b0000000000000000000010,
        S_A_START = 22'b0000000000000000000100,
        S_A_RUN   = 22'b0000000000000000001000,
        S_A_SET   = 22'b0000000000000000010000,
        S_R_DO    = 22'b0000000000000000100000,
        S_S_START = 22'b0000000000000001000000,
        S_S_WR    = 22'b0000000000000010000000,
        S_T_START = 22'b0000000000000100000000,
        S_T_REM   = 22'b0000000000001000000000,
        S_T_SL    = 22'b0000000000010000000000,
        S_T_WALK  = 22'b0000000000100000000000,
        S_TB_CHK  = 22'b0000000001000000000000,
        S_TB_FIN  = 22'b0000000010000000000000,
        S_SCAN    = 22'b0000000100000000000000,
        S_T_EVAL  = 22'b0000001000000000000000,
        S_D_START = 22'b0000010000000000000000,
        S_D_RCHK  = 22'b0000100000000000000000,
        S_D_EVAL  = 22'b0001000000000000000000,
        S_D_RUN   = 22'b0010000000000000000000,
        S_D_SEL   = 22'b0100000000000000000000,
        S_RN_EVAL = 22'b1000000000000000000000
    } t_state;

    typedef enum logic [1:0] {
        SK_TICK = 2'd0,
        SK_DISP = 2'd1,
        SK_RN   = 2'd2
    } t_skind;

    typedef enum logic [1:0] {
        RET_ADD   = 2'd0,
        RET_SLICE = 2'd1,
        RET_AGE   = 2'd2
    } t_ret;

    t_state           r_state, n_state;
    t_in              r_req, n_req;
    logic             r_err, n_err;
    logic             r_removed, n_removed;
    logic [7:0]       r_quantum;
    logic [3:0]       r_hunger;
    logic [SLOTS-1:0] r_used, n_used;
    logic [SW-1:0]    r_runner, n_runner;
    logic             r_run_v, n_run_v;
    logic [15:0]      r_ctr, n_ctr;
    t_entry           r_ent, n_ent;
    logic [SW-1:0]    r_sidx, n_sidx;
    t_ret             r_tb_ret, n_tb_ret;
    t_skind           r_skind, n_skind;
    logic [KW-1:0]    r_k, n_k;
    logic             r_rv, n_rv;
    logic [SW-1:0]    r_ridx, n_ridx;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [15:0]      r_after, n_after;
    logic             r_first, n_first;
    logic             r_bv, n_bv;
    logic [SW-1:0]    r_bidx, n_bidx;
    t_entry           r_bent, n_bent;
    logic             r_nlv, n_nlv;
    logic [LVL_W-1:0] r_nl, n_nl;
    logic [KW-1:0]    r_rn_k, n_rn_k;
    logic [15:0]      r_rn_after, n_rn_after;
    logic             r_rn_first, n_rn_first;
    t_out             r_out, n_out;
    logic             r_out_v, n_out_v;

    logic             mem_we;
    logic [SW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    t_entry           mem_a_data;
    logic [SW-1:0]    mem_b_addr;
    t_entry           mem_b_data;
    logic             rem_start;
    logic             rem_done;
    logic [7:0]       rem_val;
    logic             go_scan;
    logic             load_out;

    logic             slot_in;
    logic [SW-1:0]    sidx;
    logic [LVL_W-1:0] sc_lvl;
    logic             sc_used;
    logic             sc_cand;
    logic [3:0]       ev_wait;
    logic             ev_hungry;
    logic             ev_rise;

    psa_mem #(.SLOTS(SLOTS)) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_addr_a (r_k[SW-1:0]),
        .o_data_a (mem_a_data),
        .i_addr_b (mem_b_addr),
        .o_data_b (mem_b_data)
    );

    psa_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_req.running_pc),
        .i_divisor  (r_quantum),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    assign slot_in = (7'(r_req.slot) < 7'(SLOTS));
    assign sidx    = SW'(r_req.slot);

    assign sc_lvl  = level_of(mem_a_data);
    assign sc_used = r_used[r_ridx];
    assign sc_cand = (r_skind == SK_RN) ?
        (sc_used && (r_rn_first || mem_a_data.order_stamp > r_rn_after)) :
        (sc_used && sc_lvl == r_lvl && (r_first || mem_a_data.order_stamp > r_after));

    assign ev_wait   = (r_bent.wait_count < NIBBLE_MAX) ? r_bent.wait_count + 4'd1
                                                        : r_bent.wait_count;
    assign ev_hungry = (ev_wait >= r_hunger);
    assign ev_rise   = (r_lvl + LVL_W'(1) < LVL_W'(LEVELS)) && (r_bent.boost < NIBBLE_MAX);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_err      = r_err;
        n_removed  = r_removed;
        n_used     = r_used;
        n_runner   = r_runner;
        n_run_v    = r_run_v;
        n_ctr      = r_ctr;
        n_ent      = r_ent;
        n_sidx     = r_sidx;
        n_tb_ret   = r_tb_ret;
        n_skind    = r_skind;
        n_k        = r_k;
        n_rv       = r_rv;
        n_ridx     = r_ridx;
        n_lvl      = r_lvl;
        n_after    = r_after;
        n_first    = r_first;
        n_bv       = r_bv;
        n_bidx     = r_bidx;
        n_bent     = r_bent;
        n_nlv      = r_nlv;
        n_nl       = r_nl;
        n_rn_k     = r_rn_k;
        n_rn_after = r_rn_after;
        n_rn_first = r_rn_first;
        n_out      = r_out;
        mem_we     = 1'b0;
        mem_waddr  = r_sidx;
        mem_wdata  = r_ent;
        mem_b_addr = r_runner;
        rem_start  = 1'b0;
        go_scan    = 1'b0;
        load_out   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_in_data;
                    n_err     = 1'b0;
                    n_removed = 1'b0;
                    unique case (i_in_data.func)
                        FN_ADD:      n_state = S_A_START;
                        FN_REMOVE:   n_state = S_R_DO;
                        FN_SET:      n_state = S_S_START;
                        FN_TICK:     n_state = S_T_START;
                        FN_DISPATCH: n_state = S_D_START;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_A_START: begin
                if (!slot_in || r_used[sidx]) begin
                    n_err   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_used[sidx] = 1'b1;
                    if (r_req.is_idle && r_run_v) begin
                        n_state = S_A_RUN;
                    end else begin
                        n_state = S_A_SET;
                    end
                end
            end
            S_A_RUN: begin
                if (mem_b_data.proc_status == ST_RUN) begin
                    mem_we                = 1'b1;
                    mem_waddr             = r_runner;
                    mem_wdata             = mem_b_data;
                    mem_wdata.proc_status = ST_READY;
                    mem_wdata.wait_count  = '0;
                end
                n_state = S_A_SET;
            end
            S_A_SET: begin
                n_ent.boost      = '0;
                n_ent.wait_count = '0;
                if (r_req.is_idle) begin
                    n_ent.base_level  = '0;
                    n_ent.proc_status = ST_RUN;
                    n_runner          = sidx;
                    n_run_v           = 1'b1;
                end else begin
                    n_ent.base_level  = (7'(r_req.base_priority) > 7'(LEVELS - 1)) ?
                                        4'(LEVELS - 1) : r_req.base_priority;
                    n_ent.proc_status = (r_req.new_state == ST_RUN) ? ST_READY
                                                                    : r_req.new_state;
                end
                n_sidx   = sidx;
                n_tb_ret = RET_ADD;
                n_state  = S_TB_CHK;
            end
            S_R_DO: begin
                if (!slot_in || !r_used[sidx]) begin
                    n_err = 1'b1;
                end else begin
                    n_used[sidx] = 1'b0;
                    if (r_run_v && r_runner == sidx) begin
                        n_run_v = 1'b0;
                    end
                end
                n_state = S_DONE;
            end
            S_S_START: begin
                mem_b_addr = sidx;
                if (!slot_in || !r_used[sidx]) begin
                    n_err   = 1'b1;
                    n_state = S_DONE;
                end else if (r_req.new_state != ST_RUN) begin
                    n_state = S_S_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_S_WR: begin
                mem_we                = 1'b1;
                mem_waddr             = sidx;
                mem_wdata             = mem_b_data;
                mem_wdata.proc_status = r_req.new_state;
                n_state               = S_DONE;
            end
            S_T_START: begin
                if (r_run_v && r_used[r_runner] && r_quantum != '0 &&
                    r_req.running_pc != '0) begin
                    rem_start = 1'b1;
                    n_state   = S_T_REM;
                end else begin
                    n_state = S_T_WALK;
                end
            end
            S_T_REM: begin
                if (rem_done) begin
                    n_state = (rem_val == '0) ? S_T_SL : S_T_WALK;
                end
            end
            S_T_SL: begin
                n_ent = mem_b_data;
                if (mem_b_data.boost != '0 && level_of(mem_b_data) != LVL_W'(1)) begin
                    n_ent.boost = mem_b_data.boost - 4'd1;
                end
                n_sidx   = r_runner;
                n_tb_ret = RET_SLICE;
                n_state  = S_TB_CHK;
            end
            S_T_WALK: begin
                n_lvl   = LVL_W'(LEVELS - 1);
                n_first = 1'b1;
                n_skind = SK_TICK;
                go_scan = 1'b1;
            end
            S_TB_CHK: begin
                if (r_ctr == STAMP_MAX) begin
                    mem_we     = 1'b1;
                    n_rn_k     = '0;
                    n_rn_first = 1'b1;
                    n_skind    = SK_RN;
                    go_scan    = 1'b1;
                end else begin
                    n_state = S_TB_FIN;
                end
            end
            S_TB_FIN: begin
                mem_we                = 1'b1;
                mem_wdata.order_stamp = r_ctr;
                n_ctr                 = r_ctr + 16'd1;
                unique case (r_tb_ret)
                    RET_ADD:   n_state = S_DONE;
                    RET_SLICE: n_state = S_T_WALK;
                    RET_AGE: begin
                        n_skind = SK_TICK;
                        go_scan = 1'b1;
                    end
                    default:   n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                n_rv   = (r_k < KW'(SLOTS));
                n_ridx = r_k[SW-1:0];
                if (r_k < KW'(SLOTS)) begin
                    n_k = r_k + KW'(1);
                end
                if (r_rv) begin
                    if (sc_cand && (!r_bv || mem_a_data.order_stamp < r_bent.order_stamp)) begin
                        n_bv   = 1'b1;
                        n_bidx = r_ridx;
                        n_bent = mem_a_data;
                    end
                    if (sc_used && sc_lvl < r_lvl && (!r_nlv || sc_lvl > r_nl)) begin
                        n_nlv = 1'b1;
                        n_nl  = sc_lvl;
                    end
                end
                if (r_k == KW'(SLOTS)) begin
                    unique case (r_skind)
                        SK_TICK: n_state = S_T_EVAL;
                        SK_DISP: n_state = S_D_EVAL;
                        SK_RN:   n_state = S_RN_EVAL;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_T_EVAL: begin
                if (r_bv) begin
                    n_after = r_bent.order_stamp;
                    n_first = 1'b0;
                    if (r_bent.proc_status == ST_TERM) begin
                        n_used[r_bidx] = 1'b0;
                        if (r_run_v && r_runner == r_bidx) begin
                            n_run_v = 1'b0;
                        end
                        n_removed = 1'b1;
                        go_scan   = 1'b1;
                    end else if (r_bent.proc_status == ST_READY) begin
                        if (ev_hungry && ev_rise) begin
                            n_ent            = r_bent;
                            n_ent.wait_count = '0;
                            n_ent.boost      = r_bent.boost + 4'd1;
                            n_sidx           = r_bidx;
                            n_tb_ret         = RET_AGE;
                            n_state          = S_TB_CHK;
                        end else begin
                            mem_we               = 1'b1;
                            mem_waddr            = r_bidx;
                            mem_wdata            = r_bent;
                            mem_wdata.wait_count = ev_hungry ? 4'd0 : ev_wait;
                            go_scan              = 1'b1;
                        end
                    end else begin
                        go_scan = 1'b1;
                    end
                end else if (r_nlv && r_nl != '0) begin
                    n_lvl   = r_nl;
                    n_first = 1'b1;
                    go_scan = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_D_START: begin
                if (r_run_v) begin
                    n_state = S_D_RCHK;
                end else begin
                    n_lvl   = LVL_W'(LEVELS - 1);
                    n_first = 1'b1;
                    n_skind = SK_DISP;
                    go_scan = 1'b1;
                end
            end
            S_D_RCHK: begin
                if (mem_b_data.proc_status == ST_WAIT) begin
                    n_run_v = 1'b0;
                end
                n_lvl   = LVL_W'(LEVELS - 1);
                n_first = 1'b1;
                n_skind = SK_DISP;
                go_scan = 1'b1;
            end
            S_D_EVAL: begin
                if (r_bv) begin
                    n_after = r_bent.order_stamp;
                    n_first = 1'b0;
                    if (r_bent.proc_status == ST_READY) begin
                        n_state = r_run_v ? S_D_RUN : S_D_SEL;
                    end else if (r_run_v && r_runner == r_bidx &&
                                 r_bent.proc_status == ST_RUN) begin
                        n_state = S_DONE;
                    end else begin
                        go_scan = 1'b1;
                    end
                end else if (r_nlv) begin
                    n_lvl   = r_nl;
                    n_first = 1'b1;
                    go_scan = 1'b1;
                end else begin
                    n_run_v = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_D_RUN: begin
                mem_we                = 1'b1;
                mem_waddr             = r_runner;
                mem_wdata             = mem_b_data;
                mem_wdata.proc_status = ST_READY;
                mem_wdata.wait_count  = '0;
                n_state               = S_D_SEL;
            end
            S_D_SEL: begin
                mem_we                = 1'b1;
                mem_waddr             = r_bidx;
                mem_wdata             = r_bent;
                mem_wdata.proc_status = ST_RUN;
                mem_wdata.wait_count  = '0;
                n_runner              = r_bidx;
                n_run_v               = 1'b1;
                n_state               = S_DONE;
            end
            S_RN_EVAL: begin
                if (r_bv) begin
                    mem_we                = 1'b1;
                    mem_waddr             = r_bidx;
                    mem_wdata             = r_bent;
                    mem_wdata.order_stamp = 16'(r_rn_k);
                    n_rn_after            = r_bent.order_stamp;
                    n_rn_first            = 1'b0;
                    n_rn_k                = r_rn_k + KW'(1);
                    go_scan               = 1'b1;
                end else begin
                    n_ctr   = 16'(r_rn_k);
                    n_state = S_TB_FIN;
                end
            end
            S_DONE: begin
                if (!r_out_v || i_out_ready) begin
                    load_out           = 1'b1;
                    n_out.chosen_slot  = r_run_v ? 4'(r_runner) : 4'd0;
                    n_out.chosen_valid = r_run_v;
                    n_out.removed_any  = r_removed;
                    n_out.error        = r_err;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (go_scan) begin
            n_k     = '0;
            n_rv    = 1'b0;
            n_bv    = 1'b0;
            n_nlv   = 1'b0;
            n_state = S_SCAN;
        end

        n_out_v = load_out || (r_out_v && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_runner  <= '0;
            r_run_v   <= 1'b0;
            r_ctr     <= '0;
            r_out_v   <= 1'b0;
            r_quantum <= QUANTUM_RST;
            r_hunger  <= HUNGER_RST;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_runner <= n_runner;
            r_run_v <= n_run_v;
            r_ctr   <= n_ctr;
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    CFG_HUNGER:  r_hunger  <= i_cfg_data[3:0];
                    default:     r_quantum <= r_quantum;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_err      <= n_err;
        r_removed  <= n_removed;
        r_ent      <= n_ent;
        r_sidx     <= n_sidx;
        r_tb_ret   <= n_tb_ret;
        r_skind    <= n_skind;
        r_k        <= n_k;
        r_rv       <= n_rv;
        r_ridx     <= n_ridx;
        r_lvl      <= n_lvl;
        r_after    <= n_after;
        r_first    <= n_first;
        r_bv       <= n_bv;
        r_bidx     <= n_bidx;
        r_bent     <= n_bent;
        r_nlv      <= n_nlv;
        r_nl       <= n_nl;
        r_rn_k     <= n_rn_k;
        r_rn_after <= n_rn_after;
        r_rn_first <= n_rn_first;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire

// ===== rtl/psa_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psa_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input psa_pkg::t_out o_out_data
);
    import psa_pkg::*;

    // one transaction in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed under stall");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.chosen_valid |-> o_out_data.chosen_slot == 4'd0)
        else $error("slot reported without runner");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.removed_any && o_out_data.error))
        else $error("removal and error together");

endmodule

bind priority_scheduler_with_aging psa_chk u_psa_chk (.*);

`default_nettype wire
